[rtl/bmm_pkg.sv]
// Package with the state type and fixed field widths of the bipartite matching block.
`default_nettype none
package bmm_pkg;
    localparam int EQ_W    = 6;
    localparam int VAR_W   = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_ROOT,
        S_DEG,
        S_STEP,
        S_ADJ,
        S_OWN,
        S_POP,
        S_FLIP,
        S_FLIPRD,
        S_NEXT,
        S_OUT,
        S_CLEAR
    } state_t;
endpackage
`default_nettype wire

[rtl/bmm_if.sv]
// Handshake interfaces for the input items, result items and configuration writes.
`default_nettype none
interface bmm_item_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [bmm_pkg::EQ_W-1:0]  equation_index;
    logic [bmm_pkg::VAR_W-1:0] variable_index;
    modport source (output valid, cmd, equation_index, variable_index, input ready);
    modport sink (input valid, cmd, equation_index, variable_index, output ready);
endinterface

interface bmm_result_if;
    logic                        valid;
    logic                        ready;
    logic [bmm_pkg::EQ_W-1:0]    result_equation;
    logic                        is_matched;
    logic [bmm_pkg::VAR_W-1:0]   matched_variable;
    logic [bmm_pkg::COUNT_W-1:0] total_matched;
    logic                        edge_overflow;
    logic                        last;
    modport source (output valid, result_equation, is_matched, matched_variable,
                    total_matched, edge_overflow, last, input ready);
    modport sink (input valid, result_equation, is_matched, matched_variable,
                  total_matched, edge_overflow, last, output ready);
endinterface

interface bmm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bmm_pkg::COUNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/bipartite_max_matching_top.sv]
// Top level of the bipartite matching block: edge loading, augmenting path search, results.
//
// Add-edge beats read the equation's degree from memory and write the edge back in the
// next cycle; an edge whose equation is already full is dropped and sets the overflow flag.
// A run beat walks a depth-first search per equation, so its length depends on the graph,
// followed by one result beat per cycle while the sink is ready. The valid bits of the
// graph and match tables are cleared in the cycle after the last result is registered.
// No new input beat is taken during a run.
`default_nettype none
module bipartite_max_matching_top #(
    parameter int MAX_EQUATIONS = 64,
    parameter int MAX_VARIABLES = 64,
    parameter int MAX_DEGREE    = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bmm_item_if.sink     item,
    bmm_result_if.source result,
    bmm_cfg_if.sink      cfg
);
    localparam int EIW = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1;
    localparam int VIW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
    localparam int SW  = $clog2(MAX_DEGREE + 1);
    localparam int TW  = $clog2(MAX_EQUATIONS + 1);
    localparam int ADJ_DEPTH = MAX_EQUATIONS * MAX_DEGREE;
    localparam int AW  = (ADJ_DEPTH > 1) ? $clog2(ADJ_DEPTH) : 1;
    localparam int VW  = bmm_pkg::VAR_W;
    localparam int FW  = EIW + SW + VW;

    logic [VW-1:0]  adj_mem [ADJ_DEPTH];
    logic [SW-1:0]  deg_mem [MAX_EQUATIONS];
    logic [EIW-1:0] own_mem [MAX_VARIABLES];
    logic [VW-1:0]  par_mem [MAX_EQUATIONS];
    logic [FW-1:0]  stk_mem [MAX_EQUATIONS + 1];

    logic [VW-1:0]  adj_rd;
    logic [SW-1:0]  deg_rd;
    logic [EIW-1:0] own_rd;
    logic [VW-1:0]  par_rd;
    logic [FW-1:0]  stk_rd;

    logic           adj_re, adj_we, deg_re, deg_we, own_re, own_we, par_re, par_we;
    logic           stk_re, stk_we;
    logic [AW-1:0]  adj_raddr, adj_waddr;
    logic [VW-1:0]  adj_wdata;
    logic [EIW-1:0] deg_raddr, deg_waddr, par_raddr, par_waddr;
    logic [SW-1:0]  deg_wdata;
    logic [VIW-1:0] own_raddr, own_waddr;
    logic [EIW-1:0] own_wdata;
    logic [VW-1:0]  par_wdata;
    logic [TW-1:0]  stk_raddr, stk_waddr;
    logic [FW-1:0]  stk_wdata;

    bmm_pkg::state_t state_reg, state_next;
    logic [bmm_pkg::COUNT_W-1:0] count_reg;
    logic                 ovf_reg, ovf_next;
    logic [TW-1:0]        total_reg, total_next;
    logic [TW-1:0]        eidx_reg, eidx_next;
    logic [TW-1:0]        top_reg, top_next;
    logic [EIW-1:0]       cur_eq_reg, cur_eq_next;
    logic [SW-1:0]        cur_slot_reg, cur_slot_next;
    logic [SW-1:0]        cur_deg_reg, cur_deg_next;
    logic [VW-1:0]        cur_var_reg, cur_var_next;
    logic [EIW-1:0]       edge_eq_reg, edge_eq_next;
    logic [VW-1:0]        edge_var_reg, edge_var_next;
    logic [MAX_EQUATIONS-1:0] dvalid_reg, dvalid_next;
    logic [MAX_EQUATIONS-1:0] pvalid_reg, pvalid_next;
    logic [MAX_VARIABLES-1:0] ovalid_reg, ovalid_next;
    logic [MAX_VARIABLES-1:0] visited_reg, visited_next;

    logic                 out_valid_reg, out_valid_next;
    logic [bmm_pkg::EQ_W-1:0]    out_eq_reg, out_eq_next;
    logic                 out_m_reg, out_m_next;
    logic [VW-1:0]        out_var_reg, out_var_next;
    logic [bmm_pkg::COUNT_W-1:0] out_total_reg, out_total_next;
    logic                 out_ovf_reg, out_ovf_next;
    logic                 out_last_reg, out_last_next;

    logic [bmm_pkg::COUNT_W-1:0] run_n;
    logic [SW-1:0]        deg_val;
    logic [VIW-1:0]       vidx;
    logic                 is_last;

    assign cfg.ready   = 1'b1;
    assign run_n = (count_reg > bmm_pkg::COUNT_W'(MAX_EQUATIONS))
                   ? bmm_pkg::COUNT_W'(MAX_EQUATIONS) : count_reg;

    assign result.valid            = out_valid_reg;
    assign result.result_equation  = out_eq_reg;
    assign result.is_matched       = out_m_reg;
    assign result.matched_variable = out_var_reg;
    assign result.total_matched    = out_total_reg;
    assign result.edge_overflow    = out_ovf_reg;
    assign result.last             = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd <= adj_mem[adj_raddr];
        end
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re)
        begin
            deg_rd <= deg_mem[deg_raddr];
        end
        if (own_we)
        begin
            own_mem[own_waddr] <= own_wdata;
        end
        if (own_re)
        begin
            own_rd <= own_mem[own_raddr];
        end
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (par_re)
        begin
            par_rd <= par_mem[par_raddr];
        end
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmm_pkg::S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            eidx_reg      <= '0;
            top_reg       <= '0;
            dvalid_reg    <= '0;
            pvalid_reg    <= '0;
            ovalid_reg    <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg.valid)
            begin
                count_reg <= cfg.data;
            end
            ovf_reg       <= ovf_next;
            total_reg     <= total_next;
            eidx_reg      <= eidx_next;
            top_reg       <= top_next;
            dvalid_reg    <= dvalid_next;
            pvalid_reg    <= pvalid_next;
            ovalid_reg    <= ovalid_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_eq_reg    <= cur_eq_next;
        cur_slot_reg  <= cur_slot_next;
        cur_deg_reg   <= cur_deg_next;
        cur_var_reg   <= cur_var_next;
        edge_eq_reg   <= edge_eq_next;
        edge_var_reg  <= edge_var_next;
        out_eq_reg    <= out_eq_next;
        out_m_reg     <= out_m_next;
        out_var_reg   <= out_var_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        total_next     = total_reg;
        eidx_next      = eidx_reg;
        top_next       = top_reg;
        cur_eq_next    = cur_eq_reg;
        cur_slot_next  = cur_slot_reg;
        cur_deg_next   = cur_deg_reg;
        cur_var_next   = cur_var_reg;
        edge_eq_next   = edge_eq_reg;
        edge_var_next  = edge_var_reg;
        dvalid_next    = dvalid_reg;
        pvalid_next    = pvalid_reg;
        ovalid_next    = ovalid_reg;
        visited_next   = visited_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_eq_next    = out_eq_reg;
        out_m_next     = out_m_reg;
        out_var_next   = out_var_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        adj_re = 1'b0; adj_we = 1'b0; deg_re = 1'b0; deg_we = 1'b0;
        own_re = 1'b0; own_we = 1'b0; par_re = 1'b0; par_we = 1'b0;
        stk_re = 1'b0; stk_we = 1'b0;
        adj_raddr = AW'(cur_eq_reg) * AW'(MAX_DEGREE) + AW'(cur_slot_reg);
        deg_val   = dvalid_reg[edge_eq_reg] ? deg_rd : '0;
        adj_waddr = AW'(edge_eq_reg) * AW'(MAX_DEGREE) + AW'(deg_val);
        adj_wdata = edge_var_reg;
        deg_raddr = item.equation_index[EIW-1:0];
        deg_waddr = edge_eq_reg;
        deg_wdata = SW'(deg_val + 1'b1);
        vidx      = VIW'(adj_rd);
        own_raddr = vidx;
        own_waddr = VIW'(cur_var_reg);
        own_wdata = cur_eq_reg;
        par_raddr = eidx_reg[EIW-1:0];
        par_waddr = cur_eq_reg;
        par_wdata = cur_var_reg;
        stk_raddr = TW'(top_reg - 1'b1);
        stk_waddr = top_reg;
        stk_wdata = {cur_eq_reg, cur_slot_reg, cur_var_reg};
        is_last   = (bmm_pkg::COUNT_W'(eidx_reg) + 1'b1) == run_n;
        item.ready = 1'b0;

        case (state_reg)
            bmm_pkg::S_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    if (item.cmd == 1'b0)
                    begin
                        if ((32'(item.equation_index) < MAX_EQUATIONS)
                            && (32'(item.variable_index) < MAX_VARIABLES))
                        begin
                            edge_eq_next  = item.equation_index[EIW-1:0];
                            edge_var_next = item.variable_index;
                            deg_re        = 1'b1;
                            state_next    = bmm_pkg::S_EDGE;
                        end
                    end
                    else if (run_n == '0)
                    begin
                        state_next = bmm_pkg::S_CLEAR;
                    end
                    else
                    begin
                        eidx_next  = '0;
                        total_next = '0;
                        state_next = bmm_pkg::S_ROOT;
                    end
                end
            end
            bmm_pkg::S_EDGE:
            begin
                if (deg_val >= SW'(MAX_DEGREE))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    adj_we = 1'b1;
                    deg_we = 1'b1;
                    dvalid_next[edge_eq_reg] = 1'b1;
                end
                state_next = bmm_pkg::S_IDLE;
            end
            bmm_pkg::S_ROOT:
            begin
                cur_eq_next   = eidx_reg[EIW-1:0];
                cur_slot_next = '0;
                top_next      = '0;
                visited_next  = '0;
                deg_raddr     = eidx_reg[EIW-1:0];
                deg_re        = 1'b1;
                state_next    = bmm_pkg::S_DEG;
            end
            bmm_pkg::S_DEG:
            begin
                cur_deg_next = dvalid_reg[cur_eq_reg] ? deg_rd : '0;
                state_next   = bmm_pkg::S_STEP;
            end
            bmm_pkg::S_STEP:
            begin
                if (cur_slot_reg >= cur_deg_reg)
                begin
                    if (top_reg == '0)
                    begin
                        state_next = bmm_pkg::S_NEXT;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        top_next   = TW'(top_reg - 1'b1);
                        state_next = bmm_pkg::S_POP;
                    end
                end
                else
                begin
                    adj_re        = 1'b1;
                    cur_slot_next = SW'(cur_slot_reg + 1'b1);
                    state_next    = bmm_pkg::S_ADJ;
                end
            end
            bmm_pkg::S_ADJ:
            begin
                if (visited_reg[vidx])
                begin
                    state_next = bmm_pkg::S_STEP;
                end
                else
                begin
                    visited_next[vidx] = 1'b1;
                    cur_var_next       = adj_rd;
                    if (!ovalid_reg[vidx])
                    begin
                        state_next = bmm_pkg::S_FLIP;
                    end
                    else
                    begin
                        own_re     = 1'b1;
                        state_next = bmm_pkg::S_OWN;
                    end
                end
            end
            bmm_pkg::S_OWN:
            begin
                if (32'(top_reg) >= MAX_EQUATIONS)
                begin
                    state_next = bmm_pkg::S_STEP;
                end
                else
                begin
                    stk_we        = 1'b1;
                    top_next      = TW'(top_reg + 1'b1);
                    cur_eq_next   = own_rd;
                    cur_slot_next = '0;
                    deg_raddr     = own_rd;
                    deg_re        = 1'b1;
                    state_next    = bmm_pkg::S_DEG;
                end
            end
            bmm_pkg::S_POP:
            begin
                {cur_eq_next, cur_slot_next, cur_var_next} = stk_rd;
                deg_raddr  = stk_rd[FW-1 -: EIW];
                deg_re     = 1'b1;
                state_next = bmm_pkg::S_DEG;
            end
            bmm_pkg::S_FLIP:
            begin
                own_we = 1'b1;
                par_we = 1'b1;
                ovalid_next[VIW'(cur_var_reg)] = 1'b1;
                pvalid_next[cur_eq_reg]        = 1'b1;
                if (top_reg == '0)
                begin
                    total_next = TW'(total_reg + 1'b1);
                    state_next = bmm_pkg::S_NEXT;
                end
                else
                begin
                    stk_re     = 1'b1;
                    top_next   = TW'(top_reg - 1'b1);
                    state_next = bmm_pkg::S_FLIPRD;
                end
            end
            bmm_pkg::S_FLIPRD:
            begin
                {cur_eq_next, cur_slot_next, cur_var_next} = stk_rd;
                state_next = bmm_pkg::S_FLIP;
            end
            bmm_pkg::S_NEXT:
            begin
                if (is_last)
                begin
                    eidx_next  = '0;
                    par_raddr  = '0;
                    par_re     = 1'b1;
                    state_next = bmm_pkg::S_OUT;
                end
                else
                begin
                    eidx_next  = TW'(eidx_reg + 1'b1);
                    state_next = bmm_pkg::S_ROOT;
                end
            end
            bmm_pkg::S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_eq_next    = bmm_pkg::EQ_W'(eidx_reg);
                    out_m_next     = pvalid_reg[eidx_reg[EIW-1:0]];
                    out_var_next   = pvalid_reg[eidx_reg[EIW-1:0]] ? par_rd : '0;
                    out_total_next = bmm_pkg::COUNT_W'(total_reg);
                    out_ovf_next   = ovf_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = bmm_pkg::S_CLEAR;
                    end
                    else
                    begin
                        eidx_next = TW'(eidx_reg + 1'b1);
                        par_raddr = EIW'(eidx_reg + 1'b1);
                        par_re    = 1'b1;
                    end
                end
            end
            bmm_pkg::S_CLEAR:
            begin
                dvalid_next  = '0;
                pvalid_next  = '0;
                ovalid_next  = '0;
                visited_next = '0;
                total_next   = '0;
                ovf_next     = 1'b0;
                state_next   = bmm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bmm_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
